@@ rtl/srp_pkg.sv @@
// Shared types, widths and codes of the subtitle rectangle placement core.
package srp_pkg;

    localparam int COORD_BITS_DEF = 16;   // default width of placed sizes
    localparam int IN_BITS        = 16;   // width of one input rectangle field
    localparam int CFG_DATA_W     = 16;   // widest configuration register
    localparam int CFG_ADDR_W     = 3;
    localparam int VAL_BITS       = 31;   // scaled value, 0 .. 2^31-1
    localparam int POS_BITS       = 33;   // signed position after arranging
    localparam int SCALE_N        = 33;   // a * out + in / 2
    localparam int FIT_N          = 47;   // other * room + size / 2

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_WIDTH   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_HEIGHT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BORDER_H   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BORDER_V   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALING    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ARRANGE    = 3'd7;

    // Scaling modes
    localparam logic [1:0] SCALE_NONE = 2'd0;
    localparam logic [1:0] SCALE_ALL  = 2'd1;
    localparam logic [1:0] SCALE_SIZE = 2'd2;
    localparam logic [1:0] SCALE_BAD  = 2'd3;

    // Arrange modes, one per axis
    localparam logic [2:0] ARR_NONE       = 3'd0;
    localparam logic [2:0] ARR_MARGIN     = 3'd1;
    localparam logic [2:0] ARR_MARGIN_FIT = 3'd2;
    localparam logic [2:0] ARR_SNAP       = 3'd3;
    localparam logic [2:0] ARR_SNAP_FIT   = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] out_w;
        logic [15:0] out_h;
        logic [15:0] in_w;
        logic [15:0] in_h;
    } scale_cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] out_sz;
        logic [14:0] margin;
        logic [15:0] in_sz;
    } axis_cfg_t;

endpackage

@@ rtl/srp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module srp_div #(
    parameter int N  = 33,
    parameter int D  = 16,
    parameter int Q  = 33,
    parameter int SB = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [N-1:0]  dividend,
    input  logic [D-1:0]  divisor,
    input  logic [SB-1:0] sb_in,
    output logic          out_valid,
    output logic [Q-1:0]  quotient,
    output logic [SB-1:0] sb_out
);

    logic [D-1:0]  rem_reg  [Q];
    logic [D-1:0]  rem_next [Q];
    logic [Q-1:0]  lo_reg   [Q];
    logic [Q-1:0]  lo_next  [Q];
    logic [D-1:0]  div_reg  [Q];
    logic [D-1:0]  div_next [Q];
    logic [SB-1:0] sb_reg   [Q];
    logic [SB-1:0] sb_next  [Q];
    logic [Q-1:0]  v_reg;
    logic [N-1:0]  hi_part;

    // bits above the quotient field are below the divisor for valid operands
    assign hi_part = dividend >> Q;

    always_comb begin
        logic [D-1:0] r;
        logic [Q-1:0] l;
        logic [D-1:0] d;
        logic [D:0]   trial;
        for (int i = 0; i < Q; i++) begin
            if (i == 0) begin
                r = hi_part[D-1:0];
                l = dividend[Q-1:0];
                d = divisor;
                sb_next[i] = sb_in;
            end else begin
                r = rem_reg[i-1];
                l = lo_reg[i-1];
                d = div_reg[i-1];
                sb_next[i] = sb_reg[i-1];
            end
            trial = {r, l[Q-1]};
            if (trial >= {1'b0, d}) begin
                rem_next[i] = D'(trial - {1'b0, d});
                lo_next[i]  = {l[Q-2:0], 1'b1};
            end else begin
                rem_next[i] = trial[D-1:0];
                lo_next[i]  = {l[Q-2:0], 1'b0};
            end
            div_next[i] = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[Q-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < Q; i++) begin
                rem_reg[i] <= rem_next[i];
                lo_reg[i]  <= lo_next[i];
                div_reg[i] <= div_next[i];
                sb_reg[i]  <= sb_next[i];
            end
        end
    end

    assign out_valid = v_reg[Q-1];
    assign quotient  = lo_reg[Q-1];
    assign sb_out    = sb_reg[Q-1];

endmodule

@@ rtl/srp_scale.sv @@
// Scaling front end: out/in rescale of position and size with rounding, as the scaling mode selects.
module srp_scale (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   ce,
    input  logic                   in_valid,
    input  logic [15:0]            rect_x,
    input  logic [15:0]            rect_y,
    input  logic [15:0]            rect_w,
    input  logic [15:0]            rect_h,
    input  srp_pkg::scale_cfg_t    cfg,
    output logic                   out_valid,
    output logic [srp_pkg::VAL_BITS-1:0] out_tx,
    output logic [srp_pkg::VAL_BITS-1:0] out_ty,
    output logic [srp_pkg::VAL_BITS-1:0] out_tw,
    output logic [srp_pkg::VAL_BITS-1:0] out_th,
    output logic [15:0]            out_x,
    output logic [15:0]            out_y,
    output logic [15:0]            out_w,
    output logic [15:0]            out_h
);

    localparam int SN = srp_pkg::SCALE_N;
    localparam int VB = srp_pkg::VAL_BITS;

    logic          v1_reg;
    logic [SN-1:0] px_reg, py_reg, pw_reg, ph_reg;
    logic [15:0]   x1_reg, y1_reg, w1_reg, h1_reg;

    logic [SN-1:0] qx, qy, qw, qh;
    logic [15:0]   xd, yd, wd, hd;
    logic          vx, vy, vw, vh;

    logic          v2_reg;
    logic [VB-1:0] tx_reg, ty_reg, tw_reg, th_reg;
    logic [15:0]   x2_reg, y2_reg, w2_reg, h2_reg;
    logic [VB-1:0] sx, sy, sw, sh;

    // Drop results past the signed 32-bit range and those without divisor
    function automatic logic [VB-1:0] fix_q(input logic [SN-1:0] q, input logic [15:0] den);
        return ((den == 16'd0) || (q[SN-1:VB] != '0)) ? '0 : q[VB-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            px_reg <= SN'(rect_x) * SN'(cfg.out_w) + SN'(cfg.in_w[15:1]);
            pw_reg <= SN'(rect_w) * SN'(cfg.out_w) + SN'(cfg.in_w[15:1]);
            py_reg <= SN'(rect_y) * SN'(cfg.out_h) + SN'(cfg.in_h[15:1]);
            ph_reg <= SN'(rect_h) * SN'(cfg.out_h) + SN'(cfg.in_h[15:1]);
            x1_reg <= rect_x;
            y1_reg <= rect_y;
            w1_reg <= rect_w;
            h1_reg <= rect_h;
        end
    end

    srp_div #(.N(SN), .D(16), .Q(SN), .SB(16)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v1_reg),
        .dividend(px_reg), .divisor(cfg.in_w), .sb_in(x1_reg),
        .out_valid(vx), .quotient(qx), .sb_out(xd)
    );
    srp_div #(.N(SN), .D(16), .Q(SN), .SB(16)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v1_reg),
        .dividend(py_reg), .divisor(cfg.in_h), .sb_in(y1_reg),
        .out_valid(vy), .quotient(qy), .sb_out(yd)
    );
    srp_div #(.N(SN), .D(16), .Q(SN), .SB(16)) u_div_w (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v1_reg),
        .dividend(pw_reg), .divisor(cfg.in_w), .sb_in(w1_reg),
        .out_valid(vw), .quotient(qw), .sb_out(wd)
    );
    srp_div #(.N(SN), .D(16), .Q(SN), .SB(16)) u_div_h (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(v1_reg),
        .dividend(ph_reg), .divisor(cfg.in_h), .sb_in(h1_reg),
        .out_valid(vh), .quotient(qh), .sb_out(hd)
    );

    assign sx = fix_q(qx, cfg.in_w);
    assign sy = fix_q(qy, cfg.in_h);
    assign sw = fix_q(qw, cfg.in_w);
    assign sh = fix_q(qh, cfg.in_h);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= vx & vy & vw & vh;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tw_reg <= (cfg.mode != srp_pkg::SCALE_NONE) ? sw : VB'(wd);
            th_reg <= (cfg.mode != srp_pkg::SCALE_NONE) ? sh : VB'(hd);
            tx_reg <= (cfg.mode == srp_pkg::SCALE_ALL)  ? sx : VB'(xd);
            ty_reg <= (cfg.mode == srp_pkg::SCALE_ALL)  ? sy : VB'(yd);
            x2_reg <= xd;
            y2_reg <= yd;
            w2_reg <= wd;
            h2_reg <= hd;
        end
    end

    assign out_valid = v2_reg;
    assign out_tx    = tx_reg;
    assign out_ty    = ty_reg;
    assign out_tw    = tw_reg;
    assign out_th    = th_reg;
    assign out_x     = x2_reg;
    assign out_y     = y2_reg;
    assign out_w     = w2_reg;
    assign out_h     = h2_reg;

endmodule

@@ rtl/srp_axis.sv @@
// One axis: proportional fit into the margins in the fit modes, then clamp or snap by arrange mode.
module srp_axis #(
    parameter int SB = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  srp_pkg::axis_cfg_t            cfg,
    input  logic [srp_pkg::VAL_BITS-1:0]  sz,
    input  logic [srp_pkg::VAL_BITS-1:0]  other,
    input  logic [srp_pkg::POS_BITS-1:0]  pos,
    input  logic [15:0]                   orig_pos,
    input  logic [15:0]                   orig_sz,
    input  logic [SB-1:0]                 sb_in,
    output logic                          out_valid,
    output logic [srp_pkg::VAL_BITS-1:0]  out_sz,
    output logic [srp_pkg::VAL_BITS-1:0]  out_other,
    output logic [srp_pkg::POS_BITS-1:0]  out_pos,
    output logic [SB-1:0]                 out_sb
);

    localparam int VB  = srp_pkg::VAL_BITS;
    localparam int PB  = srp_pkg::POS_BITS;
    localparam int FN  = srp_pkg::FIT_N;
    localparam int DSB = SB + 2 * VB + PB + 1 + 32;

    function automatic logic [15:0] room_of(input logic [15:0] osz, input logic [14:0] m);
        logic signed [17:0] r;
        r = $signed({2'b00, osz}) - $signed({2'b00, m, 1'b0});
        return (r < 18'sd2) ? 16'd2 : r[15:0];
    endfunction

    logic [15:0]   room;
    logic          fit_en;

    logic          va_reg;
    logic [FN-1:0] prod_reg;
    logic [VB-1:0] sz_reg, other_reg;
    logic [PB-1:0] pos_reg;
    logic          fit_reg;
    logic [15:0]   opos_reg, osz_reg;
    logic [SB-1:0] sb_reg;

    logic           vd;
    logic [VB-1:0]  q;
    logic [DSB-1:0] dsb_in, dsb_out;
    logic [VB-1:0]  sz_d, other_d;
    logic [PB-1:0]  pos_d;
    logic           fit_d;
    logic [15:0]    opos_d, osz_d;
    logic [SB-1:0]  sb_d;

    assign room   = room_of(cfg.out_sz, cfg.margin);
    assign fit_en = (cfg.mode == srp_pkg::ARR_MARGIN_FIT) || (cfg.mode == srp_pkg::ARR_SNAP_FIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ce) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg  <= FN'(other) * FN'(room) + FN'(sz[VB-1:1]);
            fit_reg   <= fit_en && (sz > VB'(room));
            sz_reg    <= sz;
            other_reg <= other;
            pos_reg   <= pos;
            opos_reg  <= orig_pos;
            osz_reg   <= orig_sz;
            sb_reg    <= sb_in;
        end
    end

    assign dsb_in = {sz_reg, other_reg, pos_reg, fit_reg, opos_reg, osz_reg, sb_reg};

    // shrink of the other dimension: round(other * room / size)
    srp_div #(.N(FN), .D(VB), .Q(VB), .SB(DSB)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(va_reg),
        .dividend(prod_reg), .divisor(sz_reg), .sb_in(dsb_in),
        .out_valid(vd), .quotient(q), .sb_out(dsb_out)
    );

    assign {sz_d, other_d, pos_d, fit_d, opos_d, osz_d, sb_d} = dsb_out;

    logic [VB-1:0]      sz_f, other_f;
    logic signed [33:0] pos_s, near_s, far_s, sz_s, p1, res;
    logic signed [18:0] dd;
    logic signed [21:0] dx, d5, osz_s;
    logic signed [17:0] cv, cen;

    always_comb begin
        sz_f    = fit_d ? VB'(room) : sz_d;
        other_f = fit_d ? q : other_d;
        pos_s   = fit_d ? $signed(34'(cfg.margin)) : $signed({pos_d[PB-1], pos_d});
        near_s  = $signed(34'(cfg.margin));
        far_s   = $signed(34'(cfg.out_sz)) - near_s;
        sz_s    = $signed(34'(sz_f));
        dd      = $signed({2'b00, opos_d, 1'b0}) + $signed(19'(osz_d)) - $signed(19'(cfg.in_sz));
        dx      = 22'(dd);
        d5      = (dx <<< 2) + dx;
        osz_s   = $signed(22'(osz_d));
        cv      = $signed(18'(cfg.in_sz)) - $signed(18'(osz_d));
        cen     = cv / 18'sd2;
        p1      = (pos_s < near_s) ? near_s : pos_s;
        case (cfg.mode)
            srp_pkg::ARR_MARGIN, srp_pkg::ARR_MARGIN_FIT: begin
                res = (p1 + sz_s > far_s) ? far_s - sz_s : p1;
            end
            srp_pkg::ARR_SNAP, srp_pkg::ARR_SNAP_FIT: begin
                if (d5 > osz_s) begin
                    res = far_s - sz_s;
                end else if (d5 < -osz_s) begin
                    res = near_s;
                end else begin
                    res = 34'(cen);
                end
            end
            default: begin
                res = pos_s;
            end
        endcase
    end

    logic          vc_reg;
    logic [VB-1:0] szc_reg, otherc_reg;
    logic [PB-1:0] posc_reg;
    logic [SB-1:0] sbc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (ce) begin
            vc_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            szc_reg    <= sz_f;
            otherc_reg <= other_f;
            posc_reg   <= res[PB-1:0];
            sbc_reg    <= sb_d;
        end
    end

    assign out_valid = vc_reg;
    assign out_sz    = szc_reg;
    assign out_other = otherc_reg;
    assign out_pos   = posc_reg;
    assign out_sb    = sbc_reg;

endmodule

@@ rtl/subtitle_rect_place_core.sv @@
// An accepted input transaction reaches m_tvalid through the scale stage, the
//   horizontal and vertical axis stages, and the output register.
// Throughput: one rectangle per cycle while m_tready does not stall; the
//   bit-per-stage divider banks (scale, horizontal fit, vertical fit) are fully pipelined.
// A stall on m_tready freezes the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
//   register defaults: 1920x1080 in and out, no margins, scale mode 1.
module subtitle_rect_place_core #(
    parameter int COORD_BITS = srp_pkg::COORD_BITS_DEF,
    localparam int OUT_W = ((4 * COORD_BITS + 2 + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [srp_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  logic [srp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input rectangles
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,   // rect_x, rect_y, rect_w, rect_h
    // placed rectangles
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_W-1:0]                 m_tdata,   // place_x, place_y, place_w, place_h
    output logic [1:0]                       m_tuser    // needs_rescale, mode_error
);

    localparam int VB = srp_pkg::VAL_BITS;
    localparam int PB = srp_pkg::POS_BITS;
    localparam int C  = COORD_BITS;

    // configuration registers
    logic [15:0] out_w_reg, out_h_reg, in_w_reg, in_h_reg;
    logic [14:0] border_h_reg, border_v_reg;
    logic [1:0]  scaling_reg;
    logic [5:0]  arrange_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_w_reg    <= 16'd1920;
            out_h_reg    <= 16'd1080;
            in_w_reg     <= 16'd1920;
            in_h_reg     <= 16'd1080;
            border_h_reg <= '0;
            border_v_reg <= '0;
            scaling_reg  <= srp_pkg::SCALE_ALL;
            arrange_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                srp_pkg::REG_OUT_WIDTH:  out_w_reg    <= cfg_wdata;
                srp_pkg::REG_OUT_HEIGHT: out_h_reg    <= cfg_wdata;
                srp_pkg::REG_IN_WIDTH:   in_w_reg     <= cfg_wdata;
                srp_pkg::REG_IN_HEIGHT:  in_h_reg     <= cfg_wdata;
                srp_pkg::REG_BORDER_H:   border_h_reg <= cfg_wdata[14:0];
                srp_pkg::REG_BORDER_V:   border_v_reg <= cfg_wdata[14:0];
                srp_pkg::REG_SCALING:    scaling_reg  <= cfg_wdata[1:0];
                srp_pkg::REG_ARRANGE:    arrange_reg  <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    srp_pkg::scale_cfg_t scfg;
    srp_pkg::axis_cfg_t  hcfg, vcfg;

    assign scfg = '{mode: scaling_reg, out_w: out_w_reg, out_h: out_h_reg,
                    in_w: in_w_reg, in_h: in_h_reg};
    assign hcfg = '{mode: arrange_reg[2:0], out_sz: out_w_reg, margin: border_h_reg,
                    in_sz: in_w_reg};
    assign vcfg = '{mode: arrange_reg[5:3], out_sz: out_h_reg, margin: border_v_reg,
                    in_sz: in_h_reg};

    // The whole pipeline advances together whenever the output register
    // can take a new transaction; bubbles ride along as invalid slots.
    logic ce;
    logic m_tvalid_reg;
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    // Stage group 1: rescale by out/in
    logic          sv;
    logic [VB-1:0] s_tx, s_ty, s_tw, s_th;
    logic [15:0]   s_x, s_y, s_w, s_h;

    srp_scale u_scale (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s_tvalid),
        .rect_x(s_tdata[15:0]), .rect_y(s_tdata[31:16]),
        .rect_w(s_tdata[47:32]), .rect_h(s_tdata[63:48]),
        .cfg(scfg),
        .out_valid(sv), .out_tx(s_tx), .out_ty(s_ty), .out_tw(s_tw), .out_th(s_th),
        .out_x(s_x), .out_y(s_y), .out_w(s_w), .out_h(s_h)
    );

    // Stage group 2: horizontal fit and arrange; carry y position and originals
    localparam int HSB = VB + 64;
    logic           hv;
    logic [VB-1:0]  h_tw, h_th;
    logic [PB-1:0]  h_tx;
    logic [HSB-1:0] h_sb;
    logic [VB-1:0]  h_ty;
    logic [15:0]    h_x, h_y, h_w, h_h;

    srp_axis #(.SB(HSB)) u_axis_h (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(sv), .cfg(hcfg),
        .sz(s_tw), .other(s_th), .pos(PB'(s_tx)),
        .orig_pos(s_x), .orig_sz(s_w),
        .sb_in({s_ty, s_x, s_y, s_w, s_h}),
        .out_valid(hv), .out_sz(h_tw), .out_other(h_th), .out_pos(h_tx), .out_sb(h_sb)
    );

    assign {h_ty, h_x, h_y, h_w, h_h} = h_sb;

    // Stage group 3: vertical fit and arrange
    localparam int VSB = PB + 64;
    logic           vv;
    logic [VB-1:0]  v_th, v_tw;
    logic [PB-1:0]  v_ty;
    logic [VSB-1:0] v_sb;
    logic [PB-1:0]  v_tx;
    logic [15:0]    v_x, v_y, v_w, v_h;

    srp_axis #(.SB(VSB)) u_axis_v (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(hv), .cfg(vcfg),
        .sz(h_th), .other(h_tw), .pos(PB'(h_ty)),
        .orig_pos(h_y), .orig_sz(h_h),
        .sb_in({h_tx, h_x, h_y, h_w, h_h}),
        .out_valid(vv), .out_sz(v_th), .out_other(v_tw), .out_pos(v_ty), .out_sb(v_sb)
    );

    assign {v_tx, v_x, v_y, v_w, v_h} = v_sb;

    // Output stage: invalid mode passthrough, saturation, packing
    localparam logic signed [PB-1:0] S_HI = $signed(PB'((34'd1 << C) - 34'd1));
    localparam logic signed [PB-1:0] S_LO = -S_HI - PB'(1);
    localparam logic [VB-1:0]        U_HI = VB'((32'd1 << C) - 32'd1);

    logic               mode_err, rescale;
    logic signed [PB-1:0] fx, fy, cx, cy;
    logic [VB-1:0]      fw, fh, cw, ch;
    logic [OUT_W-1:0]   m_tdata_next;

    always_comb begin
        mode_err = (scaling_reg == srp_pkg::SCALE_BAD) || (arrange_reg[2:0] > srp_pkg::ARR_SNAP_FIT)
                   || (arrange_reg[5:3] > srp_pkg::ARR_SNAP_FIT);
        fx = mode_err ? $signed(PB'(v_x)) : $signed(v_tx);
        fy = mode_err ? $signed(PB'(v_y)) : $signed(v_ty);
        fw = mode_err ? VB'(v_w) : v_tw;
        fh = mode_err ? VB'(v_h) : v_th;
        rescale = !mode_err && ((v_tw != VB'(v_w)) || (v_th != VB'(v_h)));
        cx = (fx > S_HI) ? S_HI : ((fx < S_LO) ? S_LO : fx);
        cy = (fy > S_HI) ? S_HI : ((fy < S_LO) ? S_LO : fy);
        cw = (fw > U_HI) ? U_HI : fw;
        ch = (fh > U_HI) ? U_HI : fh;
        m_tdata_next = OUT_W'({ch[C-1:0], cw[C-1:0], cy[C:0], cx[C:0]});
    end

    logic [OUT_W-1:0] m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= vv;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= {mode_err, rescale};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
